>>> rtl/cll_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cll_pkg;

  typedef enum logic [4:0] {
    KIND_READ    = 5'd0,
    KIND_WRITE   = 5'd1,
    KIND_WHILE   = 5'd2,
    KIND_IF      = 5'd3,
    KIND_END     = 5'd4,
    KIND_ID      = 5'd5,
    KIND_LITERAL = 5'd6,
    KIND_GETS    = 5'd7,
    KIND_NOTEQ   = 5'd8,
    KIND_LESSEQ  = 5'd9,
    KIND_LESS    = 5'd10,
    KIND_GREATEQ = 5'd11,
    KIND_GREATER = 5'd12,
    KIND_LPAREN  = 5'd13,
    KIND_RPAREN  = 5'd14,
    KIND_ADD     = 5'd15,
    KIND_SUB     = 5'd16,
    KIND_MUL     = 5'd17,
    KIND_DIV     = 5'd18,
    KIND_EQ      = 5'd19,
    KIND_EOF     = 5'd20,
    KIND_ERROR   = 5'd21
  } kind_e;

  localparam int unsigned MODE_W = 3;
  localparam logic [MODE_W-1:0] MODE_IDLE    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_IDENT   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LIT     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_COLON   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_LESS    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_GREATER = 3'd5;
  localparam logic [MODE_W-1:0] MODE_HALT    = 3'd6;

  localparam int unsigned TEXT_W = 64;
  localparam int unsigned LEN_W  = 4;
  localparam int unsigned LINE_W = 16;
  localparam int unsigned OUT_DATA_W = 88;

  typedef struct packed {
    kind_e             kind;
    logic [TEXT_W-1:0] text;
    logic [LEN_W-1:0]  len;
    logic [LINE_W-1:0] line;
    logic              last;
  } token_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [TEXT_W-1:0] text;
    logic [LEN_W-1:0]  len;
    logic [LINE_W-1:0] line;
    logic [LINE_W-1:0] tok_line;
  } scan_state_t;

endpackage

`default_nettype wire

>>> rtl/cll_scan.sv
`timescale 1ns / 1ps
`default_nettype none

module cll_scan #(
  parameter int unsigned MAX_TEXT_LEN = 8
) (
  input  cll_pkg::scan_state_t st_i,
  input  logic [7:0]           char_i,
  input  logic                 eoi_i,
  output cll_pkg::scan_state_t st_o,
  output cll_pkg::token_t      tok0_o,
  output cll_pkg::token_t      tok1_o,
  output logic [1:0]           cnt_o
);
  import cll_pkg::*;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_MUL    = 8'h2A;
  localparam logic [7:0] CH_ADD    = 8'h2B;
  localparam logic [7:0] CH_SUB    = 8'h2D;
  localparam logic [7:0] CH_DIV    = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LESS   = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GREAT  = 8'h3E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  localparam logic [TEXT_W-1:0] KW_READ  = 64'h0000_0000_6461_6572;
  localparam logic [TEXT_W-1:0] KW_WRITE = 64'h0000_0065_7469_7277;
  localparam logic [TEXT_W-1:0] KW_WHILE = 64'h0000_0065_6c69_6877;
  localparam logic [TEXT_W-1:0] KW_IF    = 64'h0000_0000_0000_6669;
  localparam logic [TEXT_W-1:0] KW_END   = 64'h0000_0000_0064_6e65;

  function automatic token_t make_tok(kind_e kind, logic [TEXT_W-1:0] text,
                                      logic [LEN_W-1:0] len, logic [LINE_W-1:0] line);
    token_t t;
    t.kind = kind;
    t.text = text;
    t.len  = len;
    t.line = line;
    t.last = 1'b0;
    return t;
  endfunction

  logic              is_alpha, is_digit, is_space;
  logic [TEXT_W-1:0] char_text;
  kind_e             kw_kind;
  token_t            pend_tok, eof_tok, idle_tok;
  logic              pending;
  logic              idle_emit, idle_start, idle_nl;
  logic [MODE_W-1:0] idle_mode;
  logic              do_gather, do_idle, fin_idle;

  assign is_alpha  = (char_i >= 8'h61 && char_i <= 8'h7A) || (char_i >= 8'h41 && char_i <= 8'h5A);
  assign is_digit  = char_i >= 8'h30 && char_i <= 8'h39;
  assign is_space  = char_i == CH_SPACE || (char_i >= 8'h09 && char_i <= 8'h0D);
  assign char_text = {{(TEXT_W-8){1'b0}}, char_i};
  assign eof_tok   = make_tok(KIND_EOF, '0, '0, st_i.line);

  always_comb begin
    kw_kind = KIND_ID;
    if (st_i.len == 4'd4 && st_i.text == KW_READ)  kw_kind = KIND_READ;
    if (st_i.len == 4'd5 && st_i.text == KW_WRITE) kw_kind = KIND_WRITE;
    if (st_i.len == 4'd5 && st_i.text == KW_WHILE) kw_kind = KIND_WHILE;
    if (st_i.len == 4'd2 && st_i.text == KW_IF)    kw_kind = KIND_IF;
    if (st_i.len == 4'd3 && st_i.text == KW_END)   kw_kind = KIND_END;
  end

  always_comb begin
    pending  = 1'b1;
    pend_tok = make_tok(KIND_LESS, 64'(CH_LESS), 4'd1, st_i.tok_line);
    unique case (st_i.mode)
      MODE_IDENT:   pend_tok = make_tok(kw_kind, st_i.text, st_i.len, st_i.tok_line);
      MODE_LIT:     pend_tok = make_tok(KIND_LITERAL, st_i.text, st_i.len, st_i.tok_line);
      MODE_LESS:    pend_tok = make_tok(KIND_LESS, 64'(CH_LESS), 4'd1, st_i.tok_line);
      MODE_GREATER: pend_tok = make_tok(KIND_GREATER, 64'(CH_GREAT), 4'd1, st_i.tok_line);
      default:      pending  = 1'b0;
    endcase
  end

  // scan one character from the between-tokens state
  always_comb begin
    idle_emit  = 1'b0;
    idle_start = 1'b0;
    idle_nl    = 1'b0;
    idle_mode  = MODE_IDLE;
    idle_tok   = make_tok(KIND_ERROR, char_text, 4'd1, st_i.line);
    if (is_space) begin
      idle_nl = char_i == CH_NL;
    end else if (is_alpha) begin
      idle_start = 1'b1;
      idle_mode  = MODE_IDENT;
    end else if (is_digit) begin
      idle_start = 1'b1;
      idle_mode  = MODE_LIT;
    end else begin
      unique case (char_i)
        CH_COLON: begin
          idle_start = 1'b1;
          idle_mode  = MODE_COLON;
        end
        CH_LESS: begin
          idle_start = 1'b1;
          idle_mode  = MODE_LESS;
        end
        CH_GREAT: begin
          idle_start = 1'b1;
          idle_mode  = MODE_GREATER;
        end
        CH_LPAREN: begin idle_emit = 1'b1; idle_tok.kind = KIND_LPAREN; end
        CH_RPAREN: begin idle_emit = 1'b1; idle_tok.kind = KIND_RPAREN; end
        CH_ADD:    begin idle_emit = 1'b1; idle_tok.kind = KIND_ADD;    end
        CH_SUB:    begin idle_emit = 1'b1; idle_tok.kind = KIND_SUB;    end
        CH_MUL:    begin idle_emit = 1'b1; idle_tok.kind = KIND_MUL;    end
        CH_DIV:    begin idle_emit = 1'b1; idle_tok.kind = KIND_DIV;    end
        CH_EQ:     begin idle_emit = 1'b1; idle_tok.kind = KIND_EQ;     end
        default: begin
          idle_emit = 1'b1;
          idle_mode = MODE_HALT;
        end
      endcase
    end
  end

  always_comb begin
    st_o      = st_i;
    tok0_o    = make_tok(KIND_EOF, '0, '0, st_i.line);
    tok1_o    = eof_tok;
    cnt_o     = 2'd0;
    do_gather = 1'b0;
    do_idle   = 1'b0;
    fin_idle  = 1'b0;

    if (st_i.mode == MODE_HALT) begin
      st_o = st_i;
    end else if (eoi_i) begin
      st_o.mode = MODE_HALT;
      if (st_i.mode == MODE_COLON) begin
        tok0_o = make_tok(KIND_ERROR, 64'(CH_COLON), 4'd1, st_i.tok_line);
        cnt_o  = 2'd1;
      end else if (pending) begin
        tok0_o = pend_tok;
        tok1_o = eof_tok;
        cnt_o  = 2'd2;
      end else begin
        tok0_o = eof_tok;
        cnt_o  = 2'd1;
      end
    end else begin
      unique case (st_i.mode)
        MODE_IDENT: begin
          if (is_alpha || is_digit || char_i == CH_UNDER) do_gather = 1'b1;
          else fin_idle = 1'b1;
        end
        MODE_LIT: begin
          if (is_digit) do_gather = 1'b1;
          else fin_idle = 1'b1;
        end
        MODE_COLON: begin
          cnt_o = 2'd1;
          if (char_i == CH_EQ) begin
            tok0_o    = make_tok(KIND_GETS, 64'h3D3A, 4'd2, st_i.tok_line);
            st_o.mode = MODE_IDLE;
          end else begin
            tok0_o    = make_tok(KIND_ERROR, 64'(CH_COLON), 4'd1, st_i.tok_line);
            st_o.mode = MODE_HALT;
          end
        end
        MODE_LESS: begin
          if (char_i == CH_GREAT) begin
            tok0_o    = make_tok(KIND_NOTEQ, 64'h3E3C, 4'd2, st_i.tok_line);
            cnt_o     = 2'd1;
            st_o.mode = MODE_IDLE;
          end else if (char_i == CH_EQ) begin
            tok0_o    = make_tok(KIND_LESSEQ, 64'h3D3C, 4'd2, st_i.tok_line);
            cnt_o     = 2'd1;
            st_o.mode = MODE_IDLE;
          end else begin
            fin_idle = 1'b1;
          end
        end
        MODE_GREATER: begin
          if (char_i == CH_EQ) begin
            tok0_o    = make_tok(KIND_GREATEQ, 64'h3D3E, 4'd2, st_i.tok_line);
            cnt_o     = 2'd1;
            st_o.mode = MODE_IDLE;
          end else begin
            fin_idle = 1'b1;
          end
        end
        default: do_idle = 1'b1;
      endcase

      if (do_gather) begin
        if (st_i.len >= LEN_W'(MAX_TEXT_LEN)) begin
          tok0_o    = make_tok(KIND_ERROR, st_i.text, st_i.len, st_i.tok_line);
          cnt_o     = 2'd1;
          st_o.mode = MODE_HALT;
        end else begin
          for (int b = 0; b < 8; b++) begin
            if (st_i.len[2:0] == 3'(b)) st_o.text[8*b +: 8] = char_i;
          end
          st_o.len = st_i.len + 4'd1;
        end
      end

      if (fin_idle || do_idle) begin
        if (fin_idle) begin
          tok0_o = pend_tok;
          if (idle_emit) begin
            tok1_o = idle_tok;
            cnt_o  = 2'd2;
          end else begin
            cnt_o  = 2'd1;
          end
        end else if (idle_emit) begin
          tok0_o = idle_tok;
          cnt_o  = 2'd1;
        end
        st_o.mode = idle_mode;
        if (idle_start) begin
          st_o.text     = char_text;
          st_o.len      = 4'd1;
          st_o.tok_line = st_i.line;
        end
        if (idle_nl && st_i.line != {LINE_W{1'b1}}) st_o.line = st_i.line + 16'd1;
      end
    end

    tok0_o.last = cnt_o == 2'd1;
    tok1_o.last = 1'b1;
  end

endmodule

`default_nettype wire

>>> rtl/calculator_language_lexer_unit.sv
// Lexical scanner for a small calculator language. One character enters per transfer on the
// slave side (tuser high marks end of input, data ignored); tokens leave on the master side with
// kind in tuser and text, length and start line in tdata, tlast on the final token of each
// character. The block takes one character per cycle while the token queue has room for two tokens:
// the character is held in an input register, scanned combinationally and written into the token
// queue, from which its tokens are offered. A character that closes one token and is itself a token
// yields two tokens, and the master side drains one token per cycle while tready is high, so the
// sustained rate is one character per cycle as long as such pairs stay rare. An error or end of
// input halts the scanner; later characters are taken and dropped until reset.
`timescale 1ns / 1ps
`default_nettype none

module calculator_language_lexer_unit #(
  parameter int unsigned MAX_TEXT_LEN = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
  input  logic        s_axis_tuser,   // end_of_input
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [cll_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // [63:0] token_text, [67:64] token_length, [83:68] start_line, [87:84] zero
  output logic [4:0]  m_axis_tuser,   // [4:0] token_kind
  output logic        m_axis_tlast    // last_of_run
);
  import cll_pkg::*;

  localparam int unsigned QDepth = 4;
  localparam int unsigned PtrW   = $clog2(QDepth);
  localparam int unsigned CntW   = $clog2(QDepth + 1);

  logic        in_valid_q, in_valid_d;
  logic [7:0]  in_char_q;
  logic        in_eoi_q;
  logic        s_fire, process, can_proc, pop;

  scan_state_t st_q, st_d, st_scan;
  token_t      tok0, tok1;
  logic [1:0]  scan_cnt, push_cnt;

  token_t            q_mem [QDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  token_t            head;

  assign can_proc      = count_q <= CntW'(QDepth - 2);
  assign s_axis_tready = !in_valid_q || can_proc;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign process       = in_valid_q && can_proc;
  assign in_valid_d    = s_fire ? 1'b1 : (process ? 1'b0 : in_valid_q);

  cll_scan #(
    .MAX_TEXT_LEN(MAX_TEXT_LEN)
  ) u_scan (
    .st_i   (st_q),
    .char_i (in_char_q),
    .eoi_i  (in_eoi_q),
    .st_o   (st_scan),
    .tok0_o (tok0),
    .tok1_o (tok1),
    .cnt_o  (scan_cnt)
  );

  assign st_d     = process ? st_scan : st_q;
  assign push_cnt = process ? scan_cnt : 2'd0;

  assign head          = q_mem[rd_ptr_q];
  assign m_axis_tvalid = count_q != '0;
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = {{(OUT_DATA_W-TEXT_W-LEN_W-LINE_W){1'b0}}, head.line, head.len, head.text};
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.last;

  assign wr_ptr_d = wr_ptr_q + PtrW'(push_cnt);
  assign rd_ptr_d = rd_ptr_q + PtrW'(pop);
  assign count_d  = count_q + CntW'(push_cnt) - CntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      st_q.mode   <= MODE_IDLE;
      st_q.text   <= '0;
      st_q.len    <= '0;
      st_q.line   <= 16'd1;
      st_q.tok_line <= 16'd1;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      count_q     <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      st_q       <= st_d;
      wr_ptr_q   <= wr_ptr_d;
      rd_ptr_q   <= rd_ptr_d;
      count_q    <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_char_q <= s_axis_tdata;
      in_eoi_q  <= s_axis_tuser;
    end
    if (push_cnt != 2'd0) q_mem[wr_ptr_q] <= tok0;
    if (push_cnt == 2'd2) q_mem[wr_ptr_q + PtrW'(1)] <= tok1;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(QDepth))
    else $error("token queue overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    process && st_q.mode == MODE_HALT |-> push_cnt == 2'd0)
    else $error("token emitted while halted");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    process && in_eoi_q |=> st_q.mode == MODE_HALT)
    else $error("scanner not halted after end of input");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> st_q.line >= $past(st_q.line))
    else $error("line count went backward");

endmodule

`default_nettype wire
